/* hw/rtl/dns_answer_a_record_extractor_assert.svh */
// Assertion helpers for the DNS A-record extractor.
// Clock clk_i and reset rst_ni are assumed in scope.
`ifndef DNS_ANSWER_A_RECORD_EXTRACTOR_ASSERT_SVH
`define DNS_ANSWER_A_RECORD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define DNSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DNSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dnsa_pkg.sv */
`default_nettype none

package dnsa_pkg;

  typedef enum logic [1:0] {
    ST_RESOLVED  = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_QLEN     = 4'd1,
    PH_QLABEL   = 4'd2,
    PH_QTAIL    = 4'd3,
    PH_ANAME    = 4'd4,
    PH_ALEN     = 4'd5,
    PH_ALABEL   = 4'd6,
    PH_APTR     = 4'd7,
    PH_AFIXED   = 4'd8,
    PH_AADDR    = 4'd9,
    PH_ARDATA   = 4'd10,
    PH_NOTFOUND = 4'd11,
    PH_DONE     = 4'd12
  } phase_e;

  localparam logic [3:0]  HeaderBytes = 4'd12;
  localparam logic [3:0]  FixedBytes  = 4'd10;
  localparam logic [3:0]  AddrBytes   = 4'd4;
  localparam logic [7:0]  PtrMask     = 8'hC0;
  localparam logic [7:0]  LabelEnd    = 8'h00;
  localparam logic [15:0] QTailBytes  = 16'd4;
  localparam logic [15:0] TypeA       = 16'd1;
  localparam logic [15:0] ClassIn     = 16'd1;
  localparam logic [15:0] AddrLen     = 16'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic [15:0] transaction_id;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/dnsa_in_reg.sv */
`default_nettype none

module dnsa_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dnsa_pkg::byte_t in_item_i,
  input  wire logic          advance_i,
  output logic               item_valid_o,
  output dnsa_pkg::byte_t    item_o
);

  logic            valid_q, valid_d;
  dnsa_pkg::byte_t item_q;
  logic            accept;

  // full register frees up only when the parser consumes it
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

/* hw/rtl/dnsa_parser.sv */
`default_nettype none

module dnsa_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire dnsa_pkg::byte_t item_i,
  output logic                 res_valid_o,
  output dnsa_pkg::result_t    res_o
);

  dnsa_pkg::phase_e phase_q, phase_d;
  logic [3:0]  fc_q, fc_d;
  logic [15:0] qleft_q, qleft_d;
  logic [15:0] aleft_q, aleft_d;
  logic [15:0] skip_q, skip_d;
  logic [15:0] hid_q, hid_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rclass_q, rclass_d;
  logic [15:0] rlen_q, rlen_d;
  logic [31:0] addr_q, addr_d;
  logic        given_q, given_d;

  logic [7:0]  b;
  logic [3:0]  fc_inc;
  logic [15:0] skip_dec;
  logic [15:0] aleft_dec;
  logic [15:0] qleft_dec;
  dnsa_pkg::phase_e ans_phase;
  dnsa_pkg::phase_e next_ans_phase;

  assign b         = item_i.data;
  assign fc_inc    = fc_q + 4'd1;
  assign skip_dec  = skip_q - 16'd1;
  assign aleft_dec = aleft_q - 16'd1;
  assign qleft_dec = qleft_q - 16'd1;
  assign ans_phase      = (aleft_q == 16'd0) ? dnsa_pkg::PH_NOTFOUND : dnsa_pkg::PH_ANAME;
  assign next_ans_phase = (aleft_dec == 16'd0) ? dnsa_pkg::PH_NOTFOUND : dnsa_pkg::PH_ANAME;

  always_comb begin
    phase_d  = phase_q;
    fc_d     = fc_q;
    qleft_d  = qleft_q;
    aleft_d  = aleft_q;
    skip_d   = skip_q;
    hid_d    = hid_q;
    rtype_d  = rtype_q;
    rclass_d = rclass_q;
    rlen_d   = rlen_q;
    addr_d   = addr_q;
    given_d  = given_q;
    res_valid_o          = 1'b0;
    res_o.status         = dnsa_pkg::ST_RESOLVED;
    res_o.address        = 32'd0;
    res_o.transaction_id = hid_q;

    unique case (phase_q)
      dnsa_pkg::PH_HEADER: begin
        case (fc_q)
          4'd0: hid_d   = {b, 8'd0};
          4'd1: hid_d   = {hid_q[15:8], b};
          4'd4: qleft_d = {b, 8'd0};
          4'd5: qleft_d = {qleft_q[15:8], b};
          4'd6: aleft_d = {b, 8'd0};
          4'd7: aleft_d = {aleft_q[15:8], b};
          default: ;
        endcase
        fc_d = fc_inc;
        if (fc_inc == dnsa_pkg::HeaderBytes) begin
          fc_d    = 4'd0;
          phase_d = (qleft_d != 16'd0) ? dnsa_pkg::PH_QLEN : ans_phase;
        end
      end
      dnsa_pkg::PH_QLEN: begin
        if (b == dnsa_pkg::LabelEnd) begin
          skip_d  = dnsa_pkg::QTailBytes;
          phase_d = dnsa_pkg::PH_QTAIL;
        end else begin
          skip_d  = {8'd0, b};
          phase_d = dnsa_pkg::PH_QLABEL;
        end
      end
      dnsa_pkg::PH_QLABEL: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = dnsa_pkg::PH_QLEN;
        end
      end
      dnsa_pkg::PH_QTAIL: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          qleft_d = qleft_dec;
          phase_d = (qleft_dec != 16'd0) ? dnsa_pkg::PH_QLEN : ans_phase;
        end
      end
      dnsa_pkg::PH_ANAME, dnsa_pkg::PH_ALEN: begin
        // compression pointer only recognized on the first name byte
        if (phase_q == dnsa_pkg::PH_ANAME && (b & dnsa_pkg::PtrMask) == dnsa_pkg::PtrMask) begin
          phase_d = dnsa_pkg::PH_APTR;
        end else if (b == dnsa_pkg::LabelEnd) begin
          phase_d = dnsa_pkg::PH_AFIXED;
          fc_d    = 4'd0;
        end else begin
          skip_d  = {8'd0, b};
          phase_d = dnsa_pkg::PH_ALABEL;
        end
      end
      dnsa_pkg::PH_ALABEL: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = dnsa_pkg::PH_ALEN;
        end
      end
      dnsa_pkg::PH_APTR: begin
        phase_d = dnsa_pkg::PH_AFIXED;
        fc_d    = 4'd0;
      end
      dnsa_pkg::PH_AFIXED: begin
        case (fc_q)
          4'd0: rtype_d  = {b, 8'd0};
          4'd1: rtype_d  = {rtype_q[15:8], b};
          4'd2: rclass_d = {b, 8'd0};
          4'd3: rclass_d = {rclass_q[15:8], b};
          4'd8: rlen_d   = {b, 8'd0};
          4'd9: rlen_d   = {rlen_q[15:8], b};
          default: ;
        endcase
        fc_d = fc_inc;
        if (fc_inc == dnsa_pkg::FixedBytes) begin
          fc_d = 4'd0;
          if (rtype_d == dnsa_pkg::TypeA && rclass_d == dnsa_pkg::ClassIn &&
              rlen_d == dnsa_pkg::AddrLen) begin
            addr_d  = 32'd0;
            phase_d = dnsa_pkg::PH_AADDR;
          end else if (rlen_d == 16'd0) begin
            aleft_d = aleft_dec;
            phase_d = next_ans_phase;
          end else begin
            skip_d  = rlen_d;
            phase_d = dnsa_pkg::PH_ARDATA;
          end
        end
      end
      dnsa_pkg::PH_AADDR: begin
        addr_d = {addr_q[23:0], b};
        fc_d   = fc_inc;
        if (fc_inc == dnsa_pkg::AddrBytes) begin
          fc_d          = 4'd0;
          res_valid_o   = 1'b1;
          res_o.status  = dnsa_pkg::ST_RESOLVED;
          res_o.address = addr_d;
          given_d       = 1'b1;
          phase_d       = dnsa_pkg::PH_DONE;
        end
      end
      dnsa_pkg::PH_ARDATA: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          aleft_d = aleft_dec;
          phase_d = next_ans_phase;
        end
      end
      default: ;
    endcase

    if (item_i.last) begin
      if (!res_valid_o && !given_q) begin
        res_valid_o          = 1'b1;
        res_o.status         = (phase_d == dnsa_pkg::PH_NOTFOUND) ?
                               dnsa_pkg::ST_NOT_FOUND : dnsa_pkg::ST_TRUNCATED;
        res_o.address        = 32'd0;
        res_o.transaction_id = hid_d;
      end
      // back to the reset state for the next message
      phase_d  = dnsa_pkg::PH_HEADER;
      fc_d     = 4'd0;
      qleft_d  = 16'd0;
      aleft_d  = 16'd0;
      skip_d   = 16'd0;
      hid_d    = 16'd0;
      rtype_d  = 16'd0;
      rclass_d = 16'd0;
      rlen_d   = 16'd0;
      addr_d   = 32'd0;
      given_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dnsa_pkg::PH_HEADER;
      fc_q     <= 4'd0;
      qleft_q  <= 16'd0;
      aleft_q  <= 16'd0;
      skip_q   <= 16'd0;
      hid_q    <= 16'd0;
      rtype_q  <= 16'd0;
      rclass_q <= 16'd0;
      rlen_q   <= 16'd0;
      addr_q   <= 32'd0;
      given_q  <= 1'b0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      fc_q     <= fc_d;
      qleft_q  <= qleft_d;
      aleft_q  <= aleft_d;
      skip_q   <= skip_d;
      hid_q    <= hid_d;
      rtype_q  <= rtype_d;
      rclass_q <= rclass_d;
      rlen_q   <= rlen_d;
      addr_q   <= addr_d;
      given_q  <= given_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dnsa_out_reg.sv */
`default_nettype none

module dnsa_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire dnsa_pkg::result_t res_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dnsa_pkg::result_t      res_o
);

  logic              valid_q, valid_d;
  dnsa_pkg::result_t res_q;

  // holding a result the consumer has not taken yet
  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* hw/rtl/dns_answer_a_record_extractor.sv */
// A result enters the output register when the parser consumes the byte that causes it.
// Throughput: one byte per cycle if no result stalls; parser state updates once per byte.
// A stalled result holds in the output register; one more byte waits in the input register.
// Reset (async, active low) returns the parser to the header phase with all counts cleared.
`default_nettype none

`include "dns_answer_a_record_extractor_assert.svh"

module dns_answer_a_record_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      address_o,
  output logic [15:0]      transaction_id_o
);

  dnsa_pkg::byte_t   in_item;
  dnsa_pkg::byte_t   item;
  logic              item_valid;
  logic              advance;
  logic              out_busy;
  logic              res_valid;
  dnsa_pkg::result_t res;
  dnsa_pkg::result_t out_res;

  assign in_item.data = data_byte_i;
  assign in_item.last = last_byte_i;

  assign advance = item_valid && !out_busy;

  dnsa_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dnsa_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dnsa_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign status_o         = out_res.status;
  assign address_o        = out_res.address;
  assign transaction_id_o = out_res.transaction_id;

  `DNSA_ASSERT_NOW(a_addr_zero_unless_resolved,
      out_valid_o && status_o != dnsa_pkg::ST_RESOLVED, address_o == 32'd0,
      "address must be zero when not resolved")

  `DNSA_ASSERT_NOW(a_stall_means_full, in_stall_o, item_valid,
      "input stalled with empty input register")

  `DNSA_ASSERT_NEXT(a_no_advance_when_blocked, out_valid_o && out_stall_i && item_valid,
      item_valid, "input register dropped a byte while output was blocked")

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned WatchdogCycles = 200000;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned DrainCycles    = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] address;
  logic [15:0] transaction_id;

  dns_answer_a_record_extractor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .address_o        (address),
    .transaction_id_o (transaction_id)
  );

  always #5ns clk_i = ~clk_i;

  // Bytes waiting to go out, and answers the parser is predicted to give
  dnsa_pkg::byte_t   wire_bytes[$];
  dnsa_pkg::result_t predicted_results[$];
  logic [7:0] msg[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        pressure_go = 1'b0;
  logic        hold_active = 1'b0;
  logic        in_taken = 1'b0;

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_bytes = 0;
  int unsigned n_resolved = 0;
  int unsigned n_not_found = 0;
  int unsigned n_truncated = 0;
  int unsigned gen_msgs = 0;
  int unsigned gen_bytes = 0;

  // Parser shadow state
  dnsa_pkg::phase_e ph;
  logic [3:0]  fcnt;
  logic [15:0] q_left;
  logic [15:0] a_left;
  logic [15:0] skip;
  logic [15:0] hid;
  logic [15:0] rtype;
  logic [15:0] rclass;
  logic [15:0] rlen;
  logic [31:0] addr_acc;
  logic        given;

  task automatic clear_parser();
    ph = dnsa_pkg::PH_HEADER;
    fcnt = 4'd0;
    q_left = 16'd0;
    a_left = 16'd0;
    skip = 16'd0;
    hid = 16'd0;
    rtype = 16'd0;
    rclass = 16'd0;
    rlen = 16'd0;
    addr_acc = 32'd0;
    given = 1'b0;
  endtask

  function automatic dnsa_pkg::phase_e answers_phase(input logic [15:0] left);
    return (left == 16'd0) ? dnsa_pkg::PH_NOTFOUND : dnsa_pkg::PH_ANAME;
  endfunction

  task automatic next_answer();
    a_left = a_left - 16'd1;
    ph = answers_phase(a_left);
  endtask

  task automatic track_dns_byte(input logic [7:0] b, input logic last);
    dnsa_pkg::result_t res;
    logic    produced;
    produced = 1'b0;
    res = '0;
    case (ph)
      dnsa_pkg::PH_HEADER: begin
        case (fcnt)
          4'd0: hid = {b, 8'h00};
          4'd1: hid = hid | {8'h00, b};
          4'd4: q_left = {b, 8'h00};
          4'd5: q_left = q_left | {8'h00, b};
          4'd6: a_left = {b, 8'h00};
          4'd7: a_left = a_left | {8'h00, b};
          default: ;
        endcase
        fcnt = fcnt + 4'd1;
        if (fcnt == dnsa_pkg::HeaderBytes) begin
          fcnt = 4'd0;
          ph = (q_left != 16'd0) ? dnsa_pkg::PH_QLEN : answers_phase(a_left);
        end
      end
      dnsa_pkg::PH_QLEN: begin
        if (b == dnsa_pkg::LabelEnd) begin
          skip = dnsa_pkg::QTailBytes;
          ph = dnsa_pkg::PH_QTAIL;
        end else begin
          skip = {8'h00, b};
          ph = dnsa_pkg::PH_QLABEL;
        end
      end
      dnsa_pkg::PH_QLABEL: begin
        skip = skip - 16'd1;
        if (skip == 16'd0) ph = dnsa_pkg::PH_QLEN;
      end
      dnsa_pkg::PH_QTAIL: begin
        skip = skip - 16'd1;
        if (skip == 16'd0) begin
          q_left = q_left - 16'd1;
          ph = (q_left != 16'd0) ? dnsa_pkg::PH_QLEN : answers_phase(a_left);
        end
      end
      dnsa_pkg::PH_ANAME, dnsa_pkg::PH_ALEN: begin
        // compression pointer only counts as the first byte of a name
        if (ph == dnsa_pkg::PH_ANAME && (b & dnsa_pkg::PtrMask) == dnsa_pkg::PtrMask) begin
          ph = dnsa_pkg::PH_APTR;
        end else if (b == dnsa_pkg::LabelEnd) begin
          ph = dnsa_pkg::PH_AFIXED;
          fcnt = 4'd0;
        end else begin
          skip = {8'h00, b};
          ph = dnsa_pkg::PH_ALABEL;
        end
      end
      dnsa_pkg::PH_ALABEL: begin
        skip = skip - 16'd1;
        if (skip == 16'd0) ph = dnsa_pkg::PH_ALEN;
      end
      dnsa_pkg::PH_APTR: begin
        ph = dnsa_pkg::PH_AFIXED;
        fcnt = 4'd0;
      end
      dnsa_pkg::PH_AFIXED: begin
        case (fcnt)
          4'd0: rtype = {b, 8'h00};
          4'd1: rtype = rtype | {8'h00, b};
          4'd2: rclass = {b, 8'h00};
          4'd3: rclass = rclass | {8'h00, b};
          4'd8: rlen = {b, 8'h00};
          4'd9: rlen = rlen | {8'h00, b};
          default: ;
        endcase
        fcnt = fcnt + 4'd1;
        if (fcnt == dnsa_pkg::FixedBytes) begin
          fcnt = 4'd0;
          if (rtype == dnsa_pkg::TypeA && rclass == dnsa_pkg::ClassIn &&
              rlen == dnsa_pkg::AddrLen) begin
            addr_acc = 32'd0;
            ph = dnsa_pkg::PH_AADDR;
          end else if (rlen == 16'd0) begin
            next_answer();
          end else begin
            skip = rlen;
            ph = dnsa_pkg::PH_ARDATA;
          end
        end
      end
      dnsa_pkg::PH_AADDR: begin
        addr_acc = {addr_acc[23:0], b};
        fcnt = fcnt + 4'd1;
        if (fcnt == dnsa_pkg::AddrBytes) begin
          fcnt = 4'd0;
          res.status = dnsa_pkg::ST_RESOLVED;
          res.address = addr_acc;
          res.transaction_id = hid;
          produced = 1'b1;
          given = 1'b1;
          ph = dnsa_pkg::PH_DONE;
        end
      end
      dnsa_pkg::PH_ARDATA: begin
        skip = skip - 16'd1;
        if (skip == 16'd0) next_answer();
      end
      default: ;
    endcase

    if (last) begin
      if (!produced && !given) begin
        res.status = (ph == dnsa_pkg::PH_NOTFOUND) ?
                     dnsa_pkg::ST_NOT_FOUND : dnsa_pkg::ST_TRUNCATED;
        res.address = 32'd0;
        res.transaction_id = hid;
        produced = 1'b1;
      end
      clear_parser();
    end

    if (produced) begin
      predicted_results.push_back(res);
      case (res.status)
        dnsa_pkg::ST_RESOLVED:  n_resolved++;
        dnsa_pkg::ST_NOT_FOUND: n_not_found++;
        default:                n_truncated++;
      endcase
    end
  endtask

  // Message assembly
  task automatic put8(input logic [7:0] v);
    msg.push_back(v);
  endtask

  task automatic put16(input logic [15:0] v);
    msg.push_back(v[15:8]);
    msg.push_back(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] qd,
                            input logic [15:0] an);
    put16(id);
    put16(16'($urandom));
    put16(qd);
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_name(input int labels);
    int unsigned len;
    repeat (labels) begin
      len = $urandom_range(6, 1);
      put8(8'(len));
      repeat (len) put8(8'($urandom));
    end
    put8(dnsa_pkg::LabelEnd);
  endtask

  task automatic put_question(input int labels);
    put_name(labels);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  task automatic put_fixed(input logic [15:0] t, input logic [15:0] c,
                           input logic [15:0] len);
    put16(t);
    put16(c);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(len);
  endtask

  task automatic put_addr(input logic [31:0] a);
    put16(a[31:16]);
    put16(a[15:0]);
  endtask

  // Queue the first cut bytes of the message (all of it if cut is zero)
  task automatic send_msg(input int unsigned cut);
    int unsigned n;
    n = (cut == 0 || cut > msg.size()) ? msg.size() : cut;
    for (int unsigned i = 0; i < n; i++) begin
      wire_bytes.push_back('{data: msg[i], last: (i == n - 1)});
    end
    msg.delete();
    gen_msgs++;
    gen_bytes += n;
  endtask

  task automatic rand_message();
    int unsigned qd;
    int unsigned an;
    int unsigned kind;
    int unsigned cut;
    logic [15:0] len;
    if ($urandom_range(99) < 10) begin
      // raw noise, counts and lengths are whatever the bytes say
      repeat ($urandom_range(40, 1)) put8(8'($urandom));
      send_msg(0);
    end else begin
      qd = $urandom_range(2);
      an = $urandom_range(3);
      put_header(16'($urandom), 16'(qd), 16'(an));
      repeat (qd) put_question($urandom_range(3));
      repeat (an) begin
        case ($urandom_range(2))
          0: begin
            put8(dnsa_pkg::PtrMask | 8'($urandom_range(63)));
            put8(8'($urandom));
          end
          1: put_name($urandom_range(3, 1));
          default: put8(dnsa_pkg::LabelEnd);
        endcase
        kind = $urandom_range(99);
        if (kind < 35) begin
          len = dnsa_pkg::AddrLen;
          put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, len);
        end else if (kind < 55) begin
          len = 16'($urandom_range(8));
          put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, len);
        end else if (kind < 70) begin
          len = 16'($urandom_range(6));
          put_fixed(dnsa_pkg::TypeA, 16'($urandom), len);
        end else begin
          len = 16'($urandom_range(6));
          put_fixed(16'($urandom),
                    ($urandom_range(1) != 0) ? dnsa_pkg::ClassIn : 16'($urandom), len);
        end
        repeat (len) put8(8'($urandom));
      end
      repeat ($urandom_range(3)) put8(8'($urandom));
      cut = ($urandom_range(99) < 20) ? $urandom_range(msg.size(), 1) : 0;
      send_msg(cut);
    end
  endtask

  task automatic directed_messages();
    // single byte: only the id high byte is known
    put8(8'hA5);
    send_msg(0);
    // bare header, nothing asked, nothing answered
    put_header(16'hFFFF, 16'd0, 16'd0);
    send_msg(0);
    // header one byte short
    put_header(16'h1234, 16'd1, 16'd1);
    send_msg(11);
    // header ends where a question should start
    put_header(16'h5A5A, 16'd1, 16'd0);
    send_msg(0);
    // match, then trailing bytes that must be ignored
    put_header(16'hBEEF, 16'd1, 16'd1);
    put_question(1);
    put8(8'hC0);
    put8(8'h0C);
    put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, dnsa_pkg::AddrLen);
    put_addr(32'hFFFF_FFFF);
    put8(8'hAA);
    put8(8'h55);
    put8(8'h00);
    send_msg(0);
    // match whose fourth address byte is the final byte
    put_header(16'h0000, 16'd0, 16'd1);
    put8(dnsa_pkg::LabelEnd);
    put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, dnsa_pkg::AddrLen);
    put_addr(32'h0000_0000);
    send_msg(0);
    // every answer misses, followed by extra bytes, then the same without them
    for (int k = 0; k < 2; k++) begin
      put_header(16'($urandom), 16'd0, 16'd3);
      put8(8'hC1);
      put8(8'h23);
      put_fixed(dnsa_pkg::TypeA, 16'd3, dnsa_pkg::AddrLen);
      put_addr(32'($urandom));
      put8(dnsa_pkg::LabelEnd);
      put_fixed(16'd5, dnsa_pkg::ClassIn, 16'd0);
      put_name(2);
      put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, 16'd6);
      repeat (6) put8(8'($urandom));
      if (k == 0) begin
        put8(8'h12);
        put8(8'h34);
      end
      send_msg(0);
    end
    // cut inside the name of the first question
    put_header(16'($urandom), 16'd2, 16'd1);
    put_question(2);
    send_msg(15);
    // cut inside the fixed answer fields
    put_header(16'($urandom), 16'd1, 16'd1);
    put_question(0);
    put8(8'hC0);
    put8(8'h0C);
    put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, dnsa_pkg::AddrLen);
    send_msg(12 + 5 + 2 + 6);
    // cut inside skipped record data
    put_header(16'($urandom), 16'd0, 16'd1);
    put8(8'hC0);
    put8(8'h0C);
    put_fixed(16'd16, dnsa_pkg::ClassIn, 16'd5);
    repeat (5) put8(8'($urandom));
    send_msg(12 + 2 + 10 + 3);
    // pointer-looking bytes inside label runs count as plain lengths
    put_header(16'($urandom), 16'd1, 16'd1);
    put8(8'hC1);
    repeat (193) put8(8'($urandom));
    put8(dnsa_pkg::LabelEnd);
    put16(16'($urandom));
    put16(16'($urandom));
    put8(8'd3);
    repeat (3) put8(8'($urandom));
    put8(8'hC0);
    repeat (192) put8(8'($urandom));
    put8(dnsa_pkg::LabelEnd);
    put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, dnsa_pkg::AddrLen);
    put_addr(32'hC0A8_0101);
    send_msg(0);
    // long first label, A record of length zero, then a match behind a pointer
    put_header(16'($urandom), 16'd0, 16'd2);
    put8(8'h41);
    repeat (65) put8(8'($urandom));
    put8(dnsa_pkg::LabelEnd);
    put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, 16'd0);
    put8(8'hFF);
    put8(8'h12);
    put_fixed(dnsa_pkg::TypeA, dnsa_pkg::ClassIn, dnsa_pkg::AddrLen);
    put_addr(32'h0102_0304);
    send_msg(0);
    // no answers but trailing bytes
    put_header(16'($urandom), 16'd0, 16'd0);
    repeat (5) put8(8'($urandom));
    send_msg(0);
    // large counts in a short message
    put_header(16'($urandom), 16'h8001, 16'hFF00);
    put_question(1);
    send_msg(0);
  endtask

  // Sender
  always @(negedge clk_i) begin : driver
    dnsa_pkg::byte_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (wire_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = wire_bytes.pop_front();
        data_byte <= nxt.data;
        last_byte <= nxt.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk_i) begin
    out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
  end

  initial begin : hold_off
    while (!pressure_go) @(posedge clk_i);
    hold_active = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Compare results first, then predict from the byte taken at this edge
  always @(posedge clk_i) begin : monitor
    dnsa_pkg::result_t exp_res;
    in_taken <= in_valid && !in_stall;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: status %0d address %h id %h",
                 status, address, transaction_id);
          err_cnt++;
        end else begin
          exp_res = predicted_results.pop_front();
          if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            err_cnt++;
          end
          if (address !== exp_res.address) begin
            $error("address: expected %h, got %h", exp_res.address, address);
            err_cnt++;
          end
          if (transaction_id !== exp_res.transaction_id) begin
            $error("transaction_id: expected %h, got %h",
                   exp_res.transaction_id, transaction_id);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_bytes++;
        track_dns_byte(data_byte, last_byte);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == WatchdogCycles) begin
      $display("watchdog expired, %0d results still outstanding",
               predicted_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned start_bytes;
    int unsigned start_msgs;
    clear_parser();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_messages();
    for (int p = 0; p < 5; p++) begin
      @(posedge clk_i);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        default: begin
          // sender keeps pushing while the receiver holds off
          send_idle_pct = 0;
          recv_stall_pct = 0;
          pressure_go = 1'b1;
        end
      endcase
      start_bytes = gen_bytes;
      start_msgs = gen_msgs;
      while (gen_bytes - start_bytes < 70 || gen_msgs - start_msgs < 2) rand_message();
      while (wire_bytes.size() != 0) @(posedge clk_i);
    end

    while (wire_bytes.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Parsed %0d bytes in %0d messages: %0d resolved, %0d not found, %0d truncated",
             n_bytes, gen_msgs, n_resolved, n_not_found, n_truncated);
    $display("Traffic ran with no idling, sender gaps, receiver stalls, both, and a long hold");
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dnsa_pkg.sv
hw/rtl/dnsa_in_reg.sv
hw/rtl/dnsa_parser.sv
hw/rtl/dnsa_out_reg.sv
hw/rtl/dns_answer_a_record_extractor.sv
verif/testbench.sv
